// ----- rtl/mhirq_pkg.sv -----
`default_nettype none

package mhirq_pkg;

   localparam int unsigned HEAP_DEPTH_DEFAULT = 1024;
   localparam int unsigned KEY_WIDTH          = 16;
   localparam int unsigned FUNC_WIDTH         = 3;

   // Operation codes carried in the func field of an input item.
   localparam logic [FUNC_WIDTH-1:0] FUNC_INSERT   = 3'd0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_SIBLINGS = 3'd1;
   localparam logic [FUNC_WIDTH-1:0] FUNC_PARENT   = 3'd2;
   localparam logic [FUNC_WIDTH-1:0] FUNC_CHILD    = 3'd3;
   localparam logic [FUNC_WIDTH-1:0] FUNC_ROOT     = 3'd4;

   typedef struct packed {
      logic answer;
      logic status;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/mhirq_ram.sv -----
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read data.
module mhirq_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/mhirq_engine.sv -----
`default_nettype none

// Sequencer for the heap: sift-up on insert, linear key search on query.
module mhirq_engine #(
   parameter int unsigned HEAP_DEPTH = mhirq_pkg::HEAP_DEPTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   input  wire logic [mhirq_pkg::FUNC_WIDTH-1:0]      req_func,
   input  wire logic signed [mhirq_pkg::KEY_WIDTH-1:0] req_key_a,
   input  wire logic signed [mhirq_pkg::KEY_WIDTH-1:0] req_key_b,
   output logic                                       idle,
   input  wire logic                                  out_free,
   output logic                                       done,
   output mhirq_pkg::result_type                      result
);

   localparam int unsigned AW = $clog2(HEAP_DEPTH);
   localparam int unsigned CW = $clog2(HEAP_DEPTH + 2);
   localparam int unsigned KW = mhirq_pkg::KEY_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_SIFT_RD,
      ST_SIFT_CMP,
      ST_FINISH
   } state_type;

   state_type                         state_ff, state_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic [mhirq_pkg::FUNC_WIDTH-1:0]  func_ff, func_in;
   logic signed [KW-1:0]              key_a_ff, key_a_in;
   logic signed [KW-1:0]              key_b_ff, key_b_in;
   logic [CW-1:0]                     pos_ff, pos_in;
   logic [CW-1:0]                     rd_slot_ff, rd_slot_in;
   logic                              cmp_valid_ff, cmp_valid_in;
   logic [CW-1:0]                     cmp_slot_ff, cmp_slot_in;
   logic [CW-1:0]                     slot_a_ff, slot_a_in;
   logic [CW-1:0]                     slot_b_ff, slot_b_in;
   logic                              found_a_ff, found_a_in;
   logic                              found_b_ff, found_b_in;
   mhirq_pkg::result_type             result_ff, result_in;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [KW-1:0]         wr_data;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [KW-1:0]         rd_data;
   logic [CW-1:0]         rd_index;
   logic [CW-1:0]         pos_index;
   logic [CW-1:0]         parent_slot;
   logic [CW-1:0]         parent_index;

   mhirq_ram #(
      .WIDTH (KW),
      .DEPTH (HEAP_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Slot numbers are 1-based; memory addresses are slot minus one.
   assign rd_index     = rd_slot_ff - CW'(1);
   assign pos_index    = pos_ff - CW'(1);
   assign parent_slot  = pos_ff >> 1;
   assign parent_index = parent_slot - CW'(1);

   assign idle   = (state_ff == ST_IDLE);
   assign done   = (state_ff == ST_FINISH);
   assign result = result_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      func_in      = func_ff;
      key_a_in     = key_a_ff;
      key_b_in     = key_b_ff;
      pos_in       = pos_ff;
      rd_slot_in   = rd_slot_ff;
      cmp_valid_in = 1'b0;
      cmp_slot_in  = cmp_slot_ff;
      slot_a_in    = slot_a_ff;
      slot_b_in    = slot_b_ff;
      found_a_in   = found_a_ff;
      found_b_in   = found_b_ff;
      result_in    = result_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_index[AW-1:0];
      wr_data      = key_a_ff;
      rd_en        = 1'b0;
      rd_addr      = rd_index[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in    = req_func;
               key_a_in   = req_key_a;
               key_b_in   = req_key_b;
               result_in  = '0;
               rd_slot_in = CW'(1);
               slot_a_in  = '0;
               slot_b_in  = '0;
               found_a_in = 1'b0;
               found_b_in = 1'b0;
               if (req_func == mhirq_pkg::FUNC_INSERT) begin
                  if (count_ff == CW'(HEAP_DEPTH)) begin
                     result_in.status = 1'b1;
                     state_in         = ST_FINISH;
                  end else begin
                     count_in = count_ff + CW'(1);
                     pos_in   = count_ff + CW'(1);
                     state_in = ST_SIFT_RD;
                  end
               end else if (req_func == mhirq_pkg::FUNC_SIBLINGS ||
                            req_func == mhirq_pkg::FUNC_PARENT ||
                            req_func == mhirq_pkg::FUNC_CHILD ||
                            req_func == mhirq_pkg::FUNC_ROOT) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end

         ST_SCAN: begin
            // Issue stage: one slot read per cycle over the filled slots.
            if (rd_slot_ff <= count_ff) begin
               rd_en        = 1'b1;
               cmp_valid_in = 1'b1;
               cmp_slot_in  = rd_slot_ff;
               rd_slot_in   = rd_slot_ff + CW'(1);
            end else if (!cmp_valid_ff) begin
               state_in = ST_DECIDE;
            end
            // Compare stage: the first match keeps the lowest slot.
            if (cmp_valid_ff) begin
               if (!found_a_ff && (rd_data == key_a_ff)) begin
                  found_a_in = 1'b1;
                  slot_a_in  = cmp_slot_ff;
               end
               if (!found_b_ff && (rd_data == key_b_ff)) begin
                  found_b_in = 1'b1;
                  slot_b_in  = cmp_slot_ff;
               end
            end
         end

         ST_DECIDE: begin
            // An absent key keeps slot zero and takes part as it is.
            unique case (func_ff)
               mhirq_pkg::FUNC_SIBLINGS:
                  result_in.answer = ((slot_a_ff >> 1) == (slot_b_ff >> 1));
               mhirq_pkg::FUNC_PARENT:
                  result_in.answer = ((slot_b_ff >> 1) == slot_a_ff);
               mhirq_pkg::FUNC_CHILD:
                  result_in.answer = ((slot_a_ff >> 1) == slot_b_ff);
               mhirq_pkg::FUNC_ROOT:
                  result_in.answer = (slot_a_ff == CW'(1));
               default:
                  result_in.answer = 1'b0;
            endcase
            state_in = ST_FINISH;
         end

         ST_SIFT_RD: begin
            if (pos_ff == CW'(1)) begin
               wr_en    = 1'b1;
               state_in = ST_FINISH;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = parent_index[AW-1:0];
               state_in = ST_SIFT_CMP;
            end
         end

         ST_SIFT_CMP: begin
            // The new key rides in a register; the parent moves down a level.
            wr_en = 1'b1;
            if (key_a_ff < $signed(rd_data)) begin
               wr_data  = rd_data;
               pos_in   = parent_slot;
               state_in = ST_SIFT_RD;
            end else begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
      end
      func_ff     <= func_in;
      key_a_ff    <= key_a_in;
      key_b_ff    <= key_b_in;
      pos_ff      <= pos_in;
      rd_slot_ff  <= rd_slot_in;
      cmp_slot_ff <= cmp_slot_in;
      slot_a_ff   <= slot_a_in;
      slot_b_ff   <= slot_b_in;
      found_a_ff  <= found_a_in;
      found_b_ff  <= found_b_in;
      result_ff   <= result_in;
   end

endmodule

`default_nettype wire

// ----- rtl/min_heap_insert_relation_query.sv -----
// An insert runs the sift-up loop, which may climb from the new slot up to the root; a query
// reads every filled slot in turn through the one read port.
// Throughput: one item at a time; the next item is taken once the current result is queued.
// Reset (synchronous, active high) empties the heap and clears all handshake state;
// the slot memory is not cleared, as only filled slots are ever read.
`default_nettype none

module min_heap_insert_relation_query #(
   parameter int unsigned HEAP_DEPTH = mhirq_pkg::HEAP_DEPTH_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic [mhirq_pkg::FUNC_WIDTH-1:0]       req_func,
   input  wire logic signed [mhirq_pkg::KEY_WIDTH-1:0] req_key_a,
   input  wire logic signed [mhirq_pkg::KEY_WIDTH-1:0] req_key_b,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic                                        rsp_answer,
   output logic                                        rsp_status
);

   // The engine takes a new item only while it is idle. Its finished result
   // moves into the output register below, so the engine can accept the next
   // item while the previous result still waits on a stalled consumer.
   logic                  eng_idle;
   logic                  eng_done;
   logic                  out_free;
   mhirq_pkg::result_type eng_result;

   logic                  rsp_valid_ff;
   mhirq_pkg::result_type rsp_result_ff;

   // The output register can load when it is empty or is being emptied now.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !eng_idle;

   mhirq_engine #(
      .HEAP_DEPTH (HEAP_DEPTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_key_a (req_key_a),
      .req_key_b (req_key_b),
      .idle      (eng_idle),
      .out_free  (out_free),
      .done      (eng_done),
      .result    (eng_result)
   );

   // Result register: loads a finished item, drops it once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eng_done && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (eng_done && out_free) begin
         rsp_result_ff <= eng_result;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_answer = rsp_result_ff.answer;
   assign rsp_status = rsp_result_ff.status;

   // The engine is always busy in the cycle after it accepts an item.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("engine took two items in consecutive cycles");

   // A finished item handed to the output register is presented next cycle.
   a_result_presented: assert property (@(posedge clock) disable iff (reset)
      eng_done && out_free |=> rsp_valid)
      else $error("finished item was not presented");

   // Only a dropped insert sets status, and an insert never answers true.
   a_answer_status_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_answer && rsp_status))
      else $error("answer and status both set");

endmodule

`default_nettype wire
